@@ src/bcpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bcpc_pkg - shared types and constants for the battery charge controller
// word formats, register map and fixed timing constants
// ----------------------------------------------------------------------------
package bcpc_pkg;

  // input word: one timer tick
  typedef struct packed {
    logic [7:0] battery_level;
    logic [7:0] temperature_level;
    logic       button_pressed;
  } sample_word_t;

  // output word: drive levels after the tick
  typedef struct packed {
    logic relay_on;
    logic load_switch_on;
    logic cooling_down;
  } result_word_t;

  localparam int unsigned RegCount = 8;
  localparam int unsigned RegIdxW  = $clog2(RegCount);
  localparam int unsigned AddrW    = RegIdxW + 2;

  typedef enum logic [RegIdxW-1:0] {
    REG_VOLTAGE_OFF    = 3'd0,
    REG_VOLTAGE_ON     = 3'd1,
    REG_HOT            = 3'd2,
    REG_CRITICAL       = 3'd3,
    REG_SHORT_COOLDOWN = 3'd4,
    REG_LONG_COOLDOWN  = 3'd5,
    REG_SHORT_CHARGE   = 3'd6,
    REG_LONG_CHARGE    = 3'd7
  } reg_idx_t;

  // register reset values
  localparam logic [7:0] VoltageOffReset    = 8'd172;
  localparam logic [7:0] VoltageOnReset     = 8'd175;
  localparam logic [7:0] HotReset           = 8'd110;
  localparam logic [7:0] CriticalReset      = 8'd160;
  localparam logic [7:0] ShortCooldownReset = 8'd60;
  localparam logic [7:0] LongCooldownReset  = 8'd180;
  localparam logic [7:0] ShortChargeReset   = 8'd90;
  localparam logic [7:0] LongChargeReset    = 8'd180;

  // timing constants
  localparam logic [7:0] TickLowTop     = 8'd219;
  localparam logic [5:0] MinutesPerHour = 6'd60;
  localparam logic [7:0] HourMax        = 8'hff;
  localparam logic [7:0] CycleLimit     = 8'd5;
  localparam logic [7:0] DebounceTicks  = 8'd10;
  localparam logic [7:0] HoursPerReset  = 8'd10;
  localparam logic [7:0] RestartTicks   = 8'd30;

endpackage

@@ src/battery_charge_power_controller.sv @@
// ----------------------------------------------------------------------------
// battery_charge_power_controller - charge relay and load switch control
// per-tick timekeeping, charge/cooldown sequencing and undervoltage lockout
// ----------------------------------------------------------------------------
// path: a sample word accepted into the input register goes through the tick
//   update, which writes the state and the result register holding the result word
// throughput: one word per cycle; the single-pass tick update is the only
//   stage with logic, so a stall on the result side is the only limit
// reset: rst synchronous active high; clears pipeline valids and tick state,
//   relay starts on, load switch off, phase charging, registers to defaults
module battery_charge_power_controller (
  input  logic                          clk,
  input  logic                          rst,
  // sample channel
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  bcpc_pkg::sample_word_t        sample,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output bcpc_pkg::result_word_t        result,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcpc_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bcpc_pkg::*;

  typedef enum logic {
    PH_COOLDOWN = 1'b0,
    PH_CHARGING = 1'b1
  } phase_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0] voltage_off_level, voltage_on_level, hot_level, critical_level;
  logic [7:0] short_cooldown_minutes, long_cooldown_minutes;
  logic [7:0] short_charge_minutes, long_charge_minutes;

  reg_idx_t reg_idx;
  logic     reg_write;

  // byte address 4*i, low address bits ignored
  assign reg_idx   = reg_idx_t'(paddr[AddrW-1:2]);
  assign reg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_off_level      <= VoltageOffReset;
      voltage_on_level       <= VoltageOnReset;
      hot_level              <= HotReset;
      critical_level         <= CriticalReset;
      short_cooldown_minutes <= ShortCooldownReset;
      long_cooldown_minutes  <= LongCooldownReset;
      short_charge_minutes   <= ShortChargeReset;
      long_charge_minutes    <= LongChargeReset;
    end else if (reg_write) begin
      unique case (reg_idx)
        REG_VOLTAGE_OFF:    voltage_off_level      <= pwdata[7:0];
        REG_VOLTAGE_ON:     voltage_on_level       <= pwdata[7:0];
        REG_HOT:            hot_level              <= pwdata[7:0];
        REG_CRITICAL:       critical_level         <= pwdata[7:0];
        REG_SHORT_COOLDOWN: short_cooldown_minutes <= pwdata[7:0];
        REG_LONG_COOLDOWN:  long_cooldown_minutes  <= pwdata[7:0];
        REG_SHORT_CHARGE:   short_charge_minutes   <= pwdata[7:0];
        REG_LONG_CHARGE:    long_charge_minutes    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_VOLTAGE_OFF:    prdata[7:0] = voltage_off_level;
      REG_VOLTAGE_ON:     prdata[7:0] = voltage_on_level;
      REG_HOT:            prdata[7:0] = hot_level;
      REG_CRITICAL:       prdata[7:0] = critical_level;
      REG_SHORT_COOLDOWN: prdata[7:0] = short_cooldown_minutes;
      REG_LONG_COOLDOWN:  prdata[7:0] = long_cooldown_minutes;
      REG_SHORT_CHARGE:   prdata[7:0] = short_charge_minutes;
      REG_LONG_CHARGE:    prdata[7:0] = long_charge_minutes;
      default:            prdata      = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline control: input register -> tick update -> result register
  // ---------------------------------------------------------------------------
  logic         s1_valid;
  sample_word_t s1_word;
  logic         take_sample;   // word accepted on the sample channel
  logic         step;          // s1 word goes through the tick update
  logic         result_free;   // result register can load this cycle

  assign result_free  = !result_valid || !result_stall;
  assign step         = s1_valid && result_free;
  assign sample_stall = s1_valid && !result_free;
  assign take_sample  = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take_sample || (s1_valid && !step);
    end
    if (take_sample) begin
      s1_word <= sample;
    end
  end

  // ---------------------------------------------------------------------------
  // controller state
  // ---------------------------------------------------------------------------
  logic [7:0] tick_low;
  logic       tick_high;
  logic [5:0] minute_count;
  logic [7:0] hour_count;
  phase_t     phase;
  logic [7:0] cycle_count;
  logic [5:0] cooldown_start, charge_start;
  logic [7:0] cycle_hour_start;
  logic [7:0] hot_count, critical_count;
  logic       restart_pending;
  logic [7:0] restart_count;
  logic       awaiting_rise, released_flag, previous_button;
  logic       relay_state, switch_state;

  logic [7:0] tick_low_next;
  logic       tick_high_next;
  logic [5:0] minute_count_next;
  logic [7:0] hour_count_next;
  phase_t     phase_next;
  logic [7:0] cycle_count_next;
  logic [5:0] cooldown_start_next, charge_start_next;
  logic [7:0] cycle_hour_start_next;
  logic [7:0] hot_count_next, critical_count_next;
  logic       restart_pending_next;
  logic [7:0] restart_count_next;
  logic       awaiting_rise_next, released_flag_next, previous_button_next;
  logic       relay_state_next, switch_state_next;

  // elapsed span with the controller's quirk: a wrapped span is one short
  function automatic logic [7:0] span8(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    if (a > b) begin
      r = (8'hff - a) + b;
    end else begin
      r = b - a;
    end
    return r;
  endfunction

  logic [7:0] phase_len;
  logic       do_button;
  logic       clear_released;
  logic       btn;
  logic [7:0] volt, temp;

  assign btn  = s1_word.button_pressed;
  assign volt = s1_word.battery_level;
  assign temp = s1_word.temperature_level;

  always_comb begin
    tick_low_next         = tick_low;
    tick_high_next        = tick_high;
    minute_count_next     = minute_count;
    hour_count_next       = hour_count;
    phase_next            = phase;
    cycle_count_next      = cycle_count;
    cooldown_start_next   = cooldown_start;
    charge_start_next     = charge_start;
    cycle_hour_start_next = cycle_hour_start;
    hot_count_next        = hot_count;
    critical_count_next   = critical_count;
    restart_pending_next  = restart_pending;
    restart_count_next    = restart_count;
    awaiting_rise_next    = awaiting_rise;
    released_flag_next    = released_flag;
    previous_button_next  = previous_button;
    relay_state_next      = relay_state;
    switch_state_next     = switch_state;
    phase_len             = '0;
    do_button             = 1'b0;
    clear_released        = 1'b0;

    // timekeeping
    tick_low_next = tick_low + 8'd1;
    if (tick_low_next == 8'd0) begin
      tick_high_next = 1'b1;
    end
    if (tick_high_next && tick_low_next >= TickLowTop) begin
      minute_count_next = minute_count + 6'd1;
      tick_low_next     = '0;
      tick_high_next    = 1'b0;
    end
    if (minute_count_next >= MinutesPerHour) begin
      minute_count_next = '0;
      if (hour_count < HourMax) begin
        hour_count_next = hour_count + 8'd1;
      end
    end

    // charge / cooldown sequencing
    if (phase == PH_COOLDOWN) begin
      phase_len = (cycle_count < CycleLimit) ? short_cooldown_minutes
                                             : long_cooldown_minutes;
      if (span8({2'b00, cooldown_start}, {2'b00, minute_count_next}) >= phase_len) begin
        phase_next        = PH_CHARGING;
        relay_state_next  = 1'b1;
        charge_start_next = minute_count_next;
        cycle_count_next  = cycle_count + 8'd1;
      end
    end else begin
      if (span8(cycle_hour_start, hour_count_next) > HoursPerReset) begin
        hour_count_next       = '0;
        cycle_count_next      = '0;
        cycle_hour_start_next = '0;
      end
      phase_len = (cycle_count_next < CycleLimit) ? short_charge_minutes
                                                  : long_charge_minutes;
      if (span8({2'b00, charge_start}, {2'b00, minute_count_next}) >= phase_len) begin
        hot_count_next = (temp >= hot_level) ? hot_count + 8'd1 : 8'd0;
        if (hot_count_next >= DebounceTicks) begin
          phase_next            = PH_COOLDOWN;
          cycle_hour_start_next = hour_count_next;
          relay_state_next      = 1'b0;
          restart_pending_next  = 1'b0;
          hot_count_next        = '0;
          cooldown_start_next   = minute_count_next;
        end
      end else begin
        critical_count_next = (temp >= critical_level) ? critical_count + 8'd1 : 8'd0;
        if (critical_count_next >= DebounceTicks) begin
          relay_state_next = 1'b0;
        end else if (!restart_pending) begin
          relay_state_next = 1'b1;
        end
      end
      if (restart_pending_next) begin
        restart_count_next = restart_count + 8'd1;
        if (restart_count_next >= RestartTicks) begin
          restart_count_next   = '0;
          restart_pending_next = 1'b0;
          relay_state_next     = 1'b1;
        end
      end
    end

    // undervoltage lockout gates the button
    if (volt <= voltage_off_level) begin
      awaiting_rise_next = 1'b1;
      switch_state_next  = 1'b0;
    end else if (!awaiting_rise) begin
      do_button = 1'b1;
    end else if (volt >= voltage_on_level && released_flag) begin
      awaiting_rise_next = 1'b0;
      do_button          = 1'b1;
      clear_released     = 1'b1;
    end else begin
      switch_state_next  = 1'b0;
      released_flag_next = !btn;
    end

    // button handling: switch on at a press edge, release drops the relay
    if (do_button) begin
      if (btn) begin
        if (!previous_button) begin
          switch_state_next  = 1'b1;
          released_flag_next = 1'b0;
        end
      end else begin
        switch_state_next  = 1'b0;
        released_flag_next = 1'b1;
        if (previous_button) begin
          relay_state_next     = 1'b0;
          restart_pending_next = 1'b1;
        end
      end
      previous_button_next = btn;
    end
    if (clear_released) begin
      released_flag_next = 1'b0;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_low         <= '0;
      tick_high        <= 1'b0;
      minute_count     <= '0;
      hour_count       <= '0;
      phase            <= PH_CHARGING;
      cycle_count      <= '0;
      cooldown_start   <= '0;
      charge_start     <= '0;
      cycle_hour_start <= '0;
      hot_count        <= '0;
      critical_count   <= '0;
      restart_pending  <= 1'b0;
      restart_count    <= '0;
      awaiting_rise    <= 1'b0;
      released_flag    <= 1'b0;
      previous_button  <= 1'b0;
      relay_state      <= 1'b1;
      switch_state     <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      if (step) begin
        tick_low         <= tick_low_next;
        tick_high        <= tick_high_next;
        minute_count     <= minute_count_next;
        hour_count       <= hour_count_next;
        phase            <= phase_next;
        cycle_count      <= cycle_count_next;
        cooldown_start   <= cooldown_start_next;
        charge_start     <= charge_start_next;
        cycle_hour_start <= cycle_hour_start_next;
        hot_count        <= hot_count_next;
        critical_count   <= critical_count_next;
        restart_pending  <= restart_pending_next;
        restart_count    <= restart_count_next;
        awaiting_rise    <= awaiting_rise_next;
        released_flag    <= released_flag_next;
        previous_button  <= previous_button_next;
        relay_state      <= relay_state_next;
        switch_state     <= switch_state_next;
      end
      result_valid <= step || (result_valid && result_stall);
    end
    if (step) begin
      result.relay_on       <= relay_state_next;
      result.load_switch_on <= switch_state_next;
      result.cooling_down   <= (phase_next == PH_COOLDOWN);
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // entering cooldown always leaves the relay open
  a_cooldown_relay_off: assert property (@(posedge clk) disable iff (rst)
    ($past(step) && phase == PH_COOLDOWN && $past(phase) == PH_CHARGING) |-> !relay_state)
    else $error("relay closed on entry to cooldown");

  // tick counter folds into a minute before passing the top count
  a_tick_range: assert property (@(posedge clk) disable iff (rst)
    (!tick_high || tick_low < TickLowTop) && minute_count < MinutesPerHour)
    else $error("tick or minute counter out of range");

  // state moves only when a word goes through the update
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(step) |-> ($stable(minute_count) && $stable(hour_count) && $stable(phase)))
    else $error("controller state changed without a word");

  // a new result word only appears after an update
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(step))
    else $error("result word without an update");

endmodule

@@ sim/battery_charge_power_controller_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_charge_power_controller_tb - self-checking bench for the charge controller
// drives tick words through the valid/stall channels and keeps its own model of
// the relay, load switch and phase levels. Every result word is checked field by
// field. The register set is rewritten between runs while the block sits idle.
// ----------------------------------------------------------------------------
module battery_charge_power_controller_tb;
  import bcpc_pkg::*;

  localparam int QuietLimit = 2000;  // cycles with no handshake before giving up
  localparam int RunItems   = 230;   // random words per register setting
  localparam int RunCount   = 8;

  typedef enum logic {
    PH_COOLDOWN = 1'b0,
    PH_CHARGING = 1'b1
  } charge_phase_t;

  // --------------------------------------------------------------------------
  // shadow of the controller: expected levels per accepted tick
  // --------------------------------------------------------------------------
  class charge_state_tracker;
    logic [7:0]    level_cfg [RegCount];
    logic [7:0]    tick_low;
    logic          tick_high;
    logic [5:0]    minute_count;
    logic [7:0]    hour_count;
    charge_phase_t phase;
    logic [7:0]    cycle_count;
    logic [5:0]    cooldown_start;
    logic [5:0]    charge_start;
    logic [7:0]    cycle_hour_start;
    logic [7:0]    hot_count;
    logic [7:0]    critical_count;
    logic [7:0]    restart_count;
    logic          restart_pending;
    logic          awaiting_rise;
    logic          released_flag;
    logic          previous_button;
    logic          relay_state;
    logic          switch_state;
    result_word_t  pending_levels [$];
    int unsigned   mismatches;

    function new();
      level_cfg[REG_VOLTAGE_OFF]    = VoltageOffReset;
      level_cfg[REG_VOLTAGE_ON]     = VoltageOnReset;
      level_cfg[REG_HOT]            = HotReset;
      level_cfg[REG_CRITICAL]       = CriticalReset;
      level_cfg[REG_SHORT_COOLDOWN] = ShortCooldownReset;
      level_cfg[REG_LONG_COOLDOWN]  = LongCooldownReset;
      level_cfg[REG_SHORT_CHARGE]   = ShortChargeReset;
      level_cfg[REG_LONG_CHARGE]    = LongChargeReset;
      tick_low = '0; tick_high = 1'b0; minute_count = '0; hour_count = '0;
      phase = PH_CHARGING;
      cycle_count = '0; cooldown_start = '0; charge_start = '0; cycle_hour_start = '0;
      hot_count = '0; critical_count = '0; restart_count = '0; restart_pending = 1'b0;
      awaiting_rise = 1'b0; released_flag = 1'b0; previous_button = 1'b0;
      relay_state = 1'b1; switch_state = 1'b0;
      mismatches = 0;
    endfunction

    function void set_level(reg_idx_t idx, logic [7:0] v);
      level_cfg[idx] = v;
    endfunction

    // 8-bit elapsed count; a wrapped span comes out one short
    function logic [7:0] elapsed(logic [7:0] start_m, logic [7:0] now_m);
      if (start_m > now_m) return 8'(8'd255 - start_m + now_m);
      return 8'(now_m - start_m);
    endfunction

    function void step_clock();
      tick_low = tick_low + 8'd1;
      if (tick_low == 8'd0) tick_high = 1'b1;
      if (tick_high && tick_low >= TickLowTop) begin
        minute_count = minute_count + 6'd1;
        tick_low = '0;
        tick_high = 1'b0;
      end
      if (minute_count >= MinutesPerHour) begin
        minute_count = '0;
        if (hour_count < HourMax) hour_count = hour_count + 8'd1;
      end
    endfunction

    function void apply_press(logic pressed);
      if (pressed) begin
        if (!previous_button) begin
          switch_state = 1'b1;
          released_flag = 1'b0;
        end
      end else begin
        switch_state = 1'b0;
        released_flag = 1'b1;
        if (previous_button) begin
          relay_state = 1'b0;
          restart_pending = 1'b1;
        end
      end
      previous_button = pressed;
    endfunction

    function void take_tick(sample_word_t w);
      logic [7:0]   span_len;
      result_word_t lv;
      step_clock();
      if (phase == PH_COOLDOWN) begin
        span_len = (cycle_count < CycleLimit) ? level_cfg[REG_SHORT_COOLDOWN]
                                              : level_cfg[REG_LONG_COOLDOWN];
        if (elapsed({2'b00, cooldown_start}, {2'b00, minute_count}) >= span_len) begin
          phase = PH_CHARGING;
          relay_state = 1'b1;
          charge_start = minute_count;
          cycle_count = cycle_count + 8'd1;
        end
      end else begin
        if (elapsed(cycle_hour_start, hour_count) > HoursPerReset) begin
          hour_count = '0;
          cycle_count = '0;
          cycle_hour_start = '0;
        end
        span_len = (cycle_count < CycleLimit) ? level_cfg[REG_SHORT_CHARGE]
                                              : level_cfg[REG_LONG_CHARGE];
        if (elapsed({2'b00, charge_start}, {2'b00, minute_count}) >= span_len) begin
          hot_count = (w.temperature_level >= level_cfg[REG_HOT]) ? hot_count + 8'd1 : 8'd0;
          if (hot_count >= DebounceTicks) begin
            phase = PH_COOLDOWN;
            cycle_hour_start = hour_count;
            relay_state = 1'b0;
            restart_pending = 1'b0;
            hot_count = '0;
            cooldown_start = minute_count;
          end
        end else begin
          critical_count = (w.temperature_level >= level_cfg[REG_CRITICAL])
                           ? critical_count + 8'd1 : 8'd0;
          if (critical_count >= DebounceTicks) relay_state = 1'b0;
          else if (!restart_pending) relay_state = 1'b1;
        end
        if (restart_pending) begin
          restart_count = restart_count + 8'd1;
          if (restart_count >= RestartTicks) begin
            restart_count = '0;
            restart_pending = 1'b0;
            relay_state = 1'b1;
          end
        end
      end

      // undervoltage lockout gates the button
      if (w.battery_level <= level_cfg[REG_VOLTAGE_OFF]) begin
        awaiting_rise = 1'b1;
        switch_state = 1'b0;
      end else if (!awaiting_rise) begin
        apply_press(w.button_pressed);
      end else if (w.battery_level >= level_cfg[REG_VOLTAGE_ON] && released_flag) begin
        awaiting_rise = 1'b0;
        apply_press(w.button_pressed);
        released_flag = 1'b0;
      end else begin
        switch_state = 1'b0;
        released_flag = !w.button_pressed;
      end

      lv.relay_on       = relay_state;
      lv.load_switch_on = switch_state;
      lv.cooling_down   = (phase == PH_COOLDOWN);
      pending_levels.push_back(lv);
    endfunction

    function void compare_levels(result_word_t got);
      result_word_t want;
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected result word relay=%0b switch=%0b cooling=%0b",
                 $time, got.relay_on, got.load_switch_on, got.cooling_down);
        mismatches++;
        return;
      end
      want = pending_levels.pop_front();
      if (got.relay_on !== want.relay_on) begin
        $display("%0t: relay_on expected %0b got %0b", $time, want.relay_on, got.relay_on);
        mismatches++;
      end
      if (got.load_switch_on !== want.load_switch_on) begin
        $display("%0t: load_switch_on expected %0b got %0b",
                 $time, want.load_switch_on, got.load_switch_on);
        mismatches++;
      end
      if (got.cooling_down !== want.cooling_down) begin
        $display("%0t: cooling_down expected %0b got %0b",
                 $time, want.cooling_down, got.cooling_down);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block ports
  // --------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               sample_valid = 1'b0;
  logic               sample_stall;
  sample_word_t       sample = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  result_word_t       result;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  charge_state_tracker tracker = new();

  int          idle_pct = 0;     // sender gap chance per cycle
  int          stall_pct = 0;    // receiver stall chance per cycle
  int          sent_count = 0;
  int          quiet_cycles = 0;
  int unsigned bus_errors = 0;

  // stimulus runs: each field holds its value for a random stretch so that
  // debounce streaks, lockout recoveries and button holds actually form
  logic [7:0] temp_now = '0;
  logic [7:0] volt_now = '0;
  logic       btn_now = 1'b0;
  int         temp_left = 0;
  int         volt_left = 0;
  int         btn_left = 0;

  battery_charge_power_controller i_dut (
    .clk, .rst,
    .sample_valid, .sample_stall, .sample,
    .result_valid, .result_stall, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver stalls at the rate of the current pace
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // both handshakes are sampled at the edge, before any drive update lands
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (sample_valid && !sample_stall) tracker.take_tick(sample);
      if (result_valid && !result_stall) tracker.compare_levels(result);
      if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
          (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // watchdog: too long without any handshake means the block hung
  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk);
    $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
    $display("FAIL battery_charge_power_controller");
    $finish;
  end

  // --------------------------------------------------------------------------
  // drive tasks
  // --------------------------------------------------------------------------
  function automatic sample_word_t tick_word(logic [7:0] volt, logic [7:0] temp,
                                             logic pressed);
    sample_word_t w;
    w.battery_level     = volt;
    w.temperature_level = temp;
    w.button_pressed    = pressed;
    return w;
  endfunction

  // one step below, at or above a threshold
  function automatic logic [7:0] near_level(logic [7:0] lvl);
    int v;
    v = int'(lvl) + int'($urandom_range(2)) - 1;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic sample_word_t next_tick();
    if (temp_left == 0) begin
      case ($urandom_range(5))
        0: temp_now = 8'($urandom_range(255));
        1: temp_now = near_level(tracker.level_cfg[REG_HOT]);
        2: temp_now = near_level(tracker.level_cfg[REG_CRITICAL]);
        3: temp_now = 8'($urandom_range(255, tracker.level_cfg[REG_HOT]));
        4: temp_now = 8'hff;
        default: temp_now = 8'h00;
      endcase
      temp_left = $urandom_range(25, 1);
    end
    if (volt_left == 0) begin
      case ($urandom_range(5))
        0: volt_now = 8'($urandom_range(255));
        1: volt_now = near_level(tracker.level_cfg[REG_VOLTAGE_OFF]);
        2: volt_now = near_level(tracker.level_cfg[REG_VOLTAGE_ON]);
        3: volt_now = 8'($urandom_range(255, tracker.level_cfg[REG_VOLTAGE_ON]));
        4: volt_now = 8'hff;
        default: volt_now = 8'h00;
      endcase
      volt_left = $urandom_range(20, 1);
    end
    if (btn_left == 0) begin
      btn_now = 1'($urandom_range(1));
      btn_left = $urandom_range(12, 1);
    end
    temp_left--;
    volt_left--;
    btn_left--;
    return tick_word(volt_now, temp_now, btn_now);
  endfunction

  // send one word; pace changes every 60 words so gaps land on every phase
  task automatic push_sample(input sample_word_t w);
    case ((sent_count / 60) % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 65; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 65; end
      default: begin idle_pct = 36; stall_pct = 36; end
    endcase
    while ($urandom_range(99) < idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= w;
    do @(posedge clk); while (sample_stall);
    sent_count++;
  endtask

  // stop sending and wait until every expected word is back, plus a margin
  // for the two-stage pipeline
  task automatic drain_levels();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_level(input reg_idx_t idx, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), v};   // upper bits must be dropped
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_level(idx, v);
  endtask

  task automatic read_level(input reg_idx_t idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'd0, tracker.level_cfg[idx]}) begin
      $display("%0t: register %s expected %0d got %0d",
               $time, idx.name(), tracker.level_cfg[idx], prdata);
      bus_errors++;
    end
  endtask

  task automatic read_all_levels();
    for (int r = 0; r < RegCount; r++) read_level(reg_idx_t'(r));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] plan [RegCount];

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    read_all_levels();   // reset values

    // directed ticks at reset settings
    push_sample(tick_word(8'hff, 8'h00, 1'b0));  // released, switch stays off
    push_sample(tick_word(8'hff, 8'h00, 1'b1));  // rising edge turns the switch on
    push_sample(tick_word(8'hff, 8'hff, 1'b1));  // held button, critical temperature
    push_sample(tick_word(8'hff, 8'hff, 1'b0));  // release drops relay, restart pending
    push_sample(tick_word(8'h00, 8'h00, 1'b1));  // empty battery forces lockout
    push_sample(tick_word(VoltageOffReset + 8'd2, 8'hff, 1'b1)); // between levels, held
    push_sample(tick_word(VoltageOnReset, 8'h00, 1'b1));  // on level but never released
    push_sample(tick_word(VoltageOnReset, 8'h00, 1'b0));  // release arms recovery
    push_sample(tick_word(VoltageOnReset, 8'h00, 1'b1));  // recovery with a press
    push_sample(tick_word(VoltageOffReset, 8'h00, 1'b1)); // exactly at off level
    push_sample(tick_word(VoltageOffReset + 8'd1, 8'h00, 1'b0));
    push_sample(tick_word(8'hff, 8'h00, 1'b1));  // recovery and press in one tick
    // ten ticks at the critical level cut the relay
    repeat (10) push_sample(tick_word(8'hff, CriticalReset, 1'b1));
    push_sample(tick_word(8'hff, CriticalReset - 8'd1, 1'b1)); // streak broken

    for (int run = 0; run < RunCount; run++) begin
      drain_levels();
      case (run)
        0: foreach (plan[r]) plan[r] = 8'h00;  // always hot, zero-length phases
        1: foreach (plan[r]) plan[r] = 8'hff;  // lengths never reached, switch forced off
        2: plan = '{8'd100, 8'd140, 8'd120, 8'd200, 8'd0, 8'd1, 8'd0, 8'd0};
        3: plan = '{8'd90, 8'd200, 8'd60, 8'd130, 8'd0, 8'd0, 8'd1, 8'd2};
        default: begin
          for (int r = 0; r < RegCount; r++) begin
            if (r < int'(REG_SHORT_COOLDOWN))
              plan[r] = 8'($urandom_range(255));
            else
              plan[r] = ($urandom_range(7) == 0) ? 8'hff : 8'($urandom_range(2));
          end
        end
      endcase
      for (int r = 0; r < RegCount; r++) write_level(reg_idx_t'(r), plan[r]);
      read_all_levels();

      for (int n = 0; n < RunItems; n++) begin
        // hold back mid-run once until the block has caught up completely
        if (run == 2 && n == RunItems / 2) drain_levels();
        push_sample(next_tick());
      end
    end

    drain_levels();
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && bus_errors == 0 && tracker.pending_levels.size() == 0)
      $display("PASS battery_charge_power_controller");
    else
      $display("FAIL battery_charge_power_controller");
    $finish;
  end

endmodule
